FILE: hdl/dec_pkg.sv
// Package for the debounced edge counter.
// Holds the shared result type, register indexes and reset values; no dependencies.
package dec_pkg;

  // Width of the reported count fields.
  localparam int unsigned OUT_W       = 16;
  // Configuration register widths.
  localparam int unsigned FILT_W      = 4;
  localparam int unsigned CLIM_W      = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT  = 2'd1;

  // Configuration reset values.
  localparam logic [FILT_W-1:0] FILTER_LIMIT_RST = 4'd5;
  localparam logic [CLIM_W-1:0] COUNT_LIMIT_RST  = 16'd64999;

  // One result item as seen at the output port.
  typedef struct packed {
    logic [OUT_W-1:0] running_count;
    logic [OUT_W-1:0] gated_count;
    logic [OUT_W-1:0] total_count;
    logic             clean_level;
  } dec_result_t;

endpackage

FILE: hdl/dec_core.sv
// State and update logic of the debounced edge counter: integrator, debounced
// level, running, latched and total counts. Depends on dec_pkg.
module dec_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic                         pin_level,
  input  logic                         gate_tick,
  input  logic                         clear_totals,
  input  logic [dec_pkg::FILT_W-1:0]   filter_limit,
  input  logic [dec_pkg::CLIM_W-1:0]   count_limit,
  output dec_pkg::dec_result_t         result_nxt
);
  import dec_pkg::*;

  // Width that holds both a count and the count limit.
  localparam int unsigned EXT_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

  logic [COUNT_WIDTH-1:0] edge_tally_r,    edge_tally_nxt;
  logic [COUNT_WIDTH-1:0] latched_tally_r, latched_tally_nxt;
  logic [COUNT_WIDTH-1:0] grand_total_r,   grand_total_nxt;
  logic [FILT_W-1:0]      integrator_r,    integrator_nxt;
  logic                   level_r,         level_nxt;

  logic [COUNT_WIDTH-1:0] tally_gated;
  logic [COUNT_WIDTH-1:0] total_cleared;
  logic                   edge_seen;
  logic                   below_limit;
  logic [EXT_W-1:0]       tally_ext;
  logic [EXT_W-1:0]       limit_ext;
  logic [EXT_W-1:0]       run_ext;
  logic [EXT_W-1:0]       lat_ext;
  logic [EXT_W-1:0]       tot_ext;

  // Clear first, then the gate latches and accumulates the running count.
  always_comb begin
    total_cleared     = clear_totals ? '0 : grand_total_r;
    latched_tally_nxt = clear_totals ? '0 : latched_tally_r;
    grand_total_nxt   = total_cleared;
    tally_gated       = edge_tally_r;
    if (gate_tick) begin
      latched_tally_nxt = edge_tally_r;
      grand_total_nxt   = total_cleared + edge_tally_r;
      tally_gated       = '0;
    end
  end

  // Integrator: low samples count up to the filter limit, high samples down to zero.
  always_comb begin
    integrator_nxt = integrator_r;
    level_nxt      = level_r;
    edge_seen      = 1'b0;
    if (!pin_level) begin
      if (integrator_r < filter_limit) begin
        integrator_nxt = integrator_r + FILT_W'(1);
      end else if (level_r) begin
        edge_seen = 1'b1;
        level_nxt = 1'b0;
      end
    end else begin
      if (integrator_r != '0) begin
        integrator_nxt = integrator_r - FILT_W'(1);
      end else if (!level_r) begin
        edge_seen = 1'b1;
        level_nxt = 1'b1;
      end
    end
  end

  // Running count saturates at the count limit.
  assign tally_ext   = EXT_W'(tally_gated);
  assign limit_ext   = EXT_W'(count_limit);
  assign below_limit = tally_ext < limit_ext;
  assign edge_tally_nxt = (edge_seen && below_limit) ? tally_gated + COUNT_WIDTH'(1)
                                                     : tally_gated;

  // Result is the state after this update, reported in its low bits.
  assign run_ext = EXT_W'(edge_tally_nxt);
  assign lat_ext = EXT_W'(latched_tally_nxt);
  assign tot_ext = EXT_W'(grand_total_nxt);
  always_comb begin
    result_nxt.running_count = run_ext[OUT_W-1:0];
    result_nxt.gated_count   = lat_ext[OUT_W-1:0];
    result_nxt.total_count   = tot_ext[OUT_W-1:0];
    result_nxt.clean_level   = level_nxt;
  end

  // State registers advance once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_tally_r    <= '0;
      latched_tally_r <= '0;
      grand_total_r   <= '0;
      integrator_r    <= '0;
      level_r         <= 1'b0;
    end else if (step_en) begin
      edge_tally_r    <= edge_tally_nxt;
      latched_tally_r <= latched_tally_nxt;
      grand_total_r   <= grand_total_nxt;
      integrator_r    <= integrator_nxt;
      level_r         <= level_nxt;
    end
  end

endmodule

FILE: hdl/debounced_edge_counter_top.sv
// Debounced edge counter, top level: handshake, configuration registers and
// result register around dec_core. Depends on dec_pkg and dec_core.
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless the single result register is stalled.
// Reset (synchronous, rst_n low): counts, integrator and level clear, filter limit 5,
// count limit 64999, no result pending.
module debounced_edge_counter_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_pin_level,
  input  logic                             in_gate_tick,
  input  logic                             in_clear_totals,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dec_pkg::OUT_W-1:0]        out_running_count,
  output logic [dec_pkg::OUT_W-1:0]        out_gated_count,
  output logic [dec_pkg::OUT_W-1:0]        out_total_count,
  output logic                             out_clean_level,
  // Configuration write port.
  input  logic                             cfg_wr_en,
  input  logic [dec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dec_pkg::*;

  logic [FILT_W-1:0] filter_limit_r;
  logic [CLIM_W-1:0] count_limit_r;
  logic              out_valid_r;
  dec_result_t       result_r;
  dec_result_t       result_nxt;
  logic              in_accept;

  // Take a request whenever the result register is empty or being drained.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_limit_r <= FILTER_LIMIT_RST;
      count_limit_r  <= COUNT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FILTER_LIMIT: filter_limit_r <= cfg_wdata[FILT_W-1:0];
        REG_COUNT_LIMIT:  count_limit_r  <= cfg_wdata[CLIM_W-1:0];
        default:          ;
      endcase
    end
  end

  dec_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (in_accept),
    .pin_level    (in_pin_level),
    .gate_tick    (in_gate_tick),
    .clear_totals (in_clear_totals),
    .filter_limit (filter_limit_r),
    .count_limit  (count_limit_r),
    .result_nxt   (result_nxt)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted request.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_running_count = result_r.running_count;
  assign out_gated_count   = result_r.gated_count;
  assign out_total_count   = result_r.total_count;
  assign out_clean_level   = result_r.clean_level;

endmodule

FILE: tb/debounced_edge_counter_top_tb.sv
`timescale 1ns / 100ps
// Testbench for debounced_edge_counter_top: directed and random pin ticks, checked by a
// scoreboard that predicts each result. Depends on dec_pkg and the counter RTL.
module debounced_edge_counter_top_tb;
  import dec_pkg::*;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_TICKS = 175;
  // Indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Predicts the counter state tick by tick and checks results in order.
  class edge_count_board;
    logic [FILT_W-1:0] filter_limit;
    logic [CLIM_W-1:0] count_limit;
    logic [OUT_W-1:0]  edge_tally;
    logic [OUT_W-1:0]  latched_tally;
    logic [OUT_W-1:0]  grand_total;
    logic [FILT_W-1:0] integ;
    logic              level;
    dec_result_t       expected_counts[$];
    int                errors;

    function new();
      filter_limit  = FILTER_LIMIT_RST;
      count_limit   = COUNT_LIMIT_RST;
      edge_tally    = '0;
      latched_tally = '0;
      grand_total   = '0;
      integ         = '0;
      level         = 1'b0;
      errors        = 0;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%0t ns: mismatch: %s", $time, what);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FILTER_LIMIT: filter_limit = data[FILT_W-1:0];
        REG_COUNT_LIMIT:  count_limit  = data[CLIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Applies one accepted request and queues the result it should produce.
    function void note_tick(logic pin, logic gate, logic clr);
      logic        edge_seen;
      dec_result_t want;
      edge_seen = 1'b0;
      // A clear acts before the gate in the same tick.
      if (clr) begin
        latched_tally = '0;
        grand_total   = '0;
      end
      if (gate) begin
        latched_tally = edge_tally;
        grand_total   = grand_total + edge_tally;
        edge_tally    = '0;
      end
      // Integrator: low samples count up to the filter limit, high samples down to zero.
      if (!pin) begin
        if (integ < filter_limit) begin
          integ = integ + 1'b1;
        end else if (level) begin
          edge_seen = 1'b1;
          level     = 1'b0;
        end
      end else begin
        if (integ != '0) begin
          integ = integ - 1'b1;
        end else if (!level) begin
          edge_seen = 1'b1;
          level     = 1'b1;
        end
      end
      // The running count stops at the count limit.
      if (edge_seen && edge_tally < count_limit) edge_tally = edge_tally + 1'b1;
      want.running_count = edge_tally;
      want.gated_count   = latched_tally;
      want.total_count   = grand_total;
      want.clean_level   = level;
      expected_counts.push_back(want);
    endfunction

    function void check_counts(dec_result_t got);
      dec_result_t want;
      if (expected_counts.size() == 0) begin
        flag($sformatf("result with nothing expected: running %0d gated %0d total %0d",
                       got.running_count, got.gated_count, got.total_count));
        return;
      end
      want = expected_counts.pop_front();
      if (got.running_count !== want.running_count)
        flag($sformatf("running_count expected %0d got %0d",
                       want.running_count, got.running_count));
      if (got.gated_count !== want.gated_count)
        flag($sformatf("gated_count expected %0d got %0d", want.gated_count, got.gated_count));
      if (got.total_count !== want.total_count)
        flag($sformatf("total_count expected %0d got %0d", want.total_count, got.total_count));
      if (got.clean_level !== want.clean_level)
        flag($sformatf("clean_level expected %0b got %0b", want.clean_level, got.clean_level));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_pin_level;
  logic in_gate_tick;
  logic in_clear_totals;
  logic out_valid;
  logic out_stall;
  logic [OUT_W-1:0] out_running_count;
  logic [OUT_W-1:0] out_gated_count;
  logic [OUT_W-1:0] out_total_count;
  logic out_clean_level;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  edge_count_board sb;
  int unsigned long_hold_reqs;
  int unsigned cycle_count;

  debounced_edge_counter_top #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pin_level(in_pin_level),
    .in_gate_tick(in_gate_tick),
    .in_clear_totals(in_clear_totals),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_running_count(out_running_count),
    .out_gated_count(out_gated_count),
    .out_total_count(out_total_count),
    .out_clean_level(out_clean_level),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch both channels and feed the scoreboard at each handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(in_pin_level, in_gate_tick, in_clear_totals);
      if (out_valid && !out_stall)
        sb.check_counts('{out_running_count, out_gated_count, out_total_count,
                          out_clean_level});
    end
  end

  // Receiver: windows of random stall density, plus long hold-offs on request.
  always @(posedge clk) begin : receiver
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned window_left;
    int unsigned stall_pct;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done != long_hold_reqs) begin
      holds_done = long_hold_reqs;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (window_left == 0) begin
        case ($urandom_range(4))
          0, 1: stall_pct = 0;
          2: stall_pct = 20;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        window_left = $urandom_range(20, 80);
      end else begin
        window_left--;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Ends the run with errors once the cycle limit is reached.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one request and returns after the edge at which it is taken.
  task automatic send_tick(logic pin, logic gate, logic clr);
    in_valid        <= 1'b1;
    in_pin_level    <= pin;
    in_gate_tick    <= gate;
    in_clear_totals <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_counts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes both registers and pokes the two unused indexes with random data.
  task automatic apply_settings(logic [FILT_W-1:0] filt, logic [CLIM_W-1:0] clim);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    for (int r = 0; r < 4; r++) begin
      data = CFG_DATA_W'($urandom());
      if (r == 0) begin
        idx = REG_FILTER_LIMIT;
        data[FILT_W-1:0] = filt;
      end else if (r == 1) begin
        idx  = REG_COUNT_LIMIT;
        data = clim;
      end else if (r == 2) begin
        idx = REG_SPARE_A;
      end else begin
        idx = REG_SPARE_B;
      end
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      @(posedge clk);
      sb.write_reg(idx, data);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [FILT_W-1:0] filt_plan[PHASES];
    logic [CLIM_W-1:0] clim_plan[PHASES];
    int unsigned sent;
    int unsigned burst;
    int unsigned run_left;
    logic        run_level;
    logic        noisy;
    logic        pin;

    sb              = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_pin_level    = 1'b0;
    in_gate_tick    = 1'b0;
    in_clear_totals = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    long_hold_reqs  = 0;
    run_left        = 0;
    run_level       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the first high sample is a rising edge at once, then the
    // integrator climbs.
    send_tick(1'b1, 1'b0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0);

    // Filter limit lowered below the integrator: a low sample falls at once.
    // Then gate alone, clear with gate, and clear alone.
    drain_results();
    apply_settings(4'd2, COUNT_LIMIT_RST);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);

    // Filter limit zero with count limit zero: level moves, nothing is counted.
    drain_results();
    apply_settings(4'd0, 16'd0);
    repeat (3) send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);

    // Count limit 1: rise hits the limit, fall is not counted, gate restarts the count.
    drain_results();
    apply_settings(4'd0, 16'd1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);

    // Random phases, each under its own register settings.
    filt_plan[0] = 4'd1;
    clim_plan[0] = 16'hFFFF;
    filt_plan[1] = 4'd15;
    clim_plan[1] = 16'd0;
    filt_plan[2] = 4'd0;
    clim_plan[2] = 16'd3;
    filt_plan[3] = FILT_W'($urandom_range(1, 14));
    clim_plan[3] = CLIM_W'($urandom_range(1, 40));
    filt_plan[4] = FILTER_LIMIT_RST;
    clim_plan[4] = COUNT_LIMIT_RST;
    filt_plan[5] = FILT_W'($urandom_range(0, 15));
    clim_plan[5] = CLIM_W'($urandom());

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      apply_settings(filt_plan[ph], clim_plan[ph]);
      // Hold the receiver off while requests keep coming, so the block backs up.
      if (ph == 2 || ph == 5) long_hold_reqs++;
      sent = 0;
      while (sent < PHASE_TICKS) begin
        burst = $urandom_range(1, 24);
        noisy = ($urandom_range(4) == 0);
        for (int b = 0; b < burst && sent < PHASE_TICKS; b++) begin
          // Mostly steady runs with rare glitches; some bursts are pure noise.
          if (noisy) begin
            pin = 1'($urandom_range(1));
          end else begin
            if (run_left == 0) begin
              run_level = ~run_level;
              run_left  = $urandom_range(1, 24);
            end
            run_left--;
            pin = run_level ^ ($urandom_range(9) == 0);
          end
          send_tick(pin, $urandom_range(15) == 0, $urandom_range(31) == 0);
          sent++;
        end
        if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 6));
      end
    end

    drain_results();
    if (sb.expected_counts.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.expected_counts.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
